>>> rtl/core/aes_cfb_pkg.sv
// Shared constants, S-box table and round functions for the AES-128 CFB128 cipher.
package aes_cfb_pkg;

    // Block and stream geometry.
    localparam int BLK_W        = 128;
    localparam int HALF_W       = 64;
    localparam int CNT_W        = 5;
    localparam int CNT_LSB      = 2 * HALF_W;
    localparam int TDATA_W      = ((CNT_LSB + CNT_W + 7) / 8) * 8;
    localparam int PAD_W        = TDATA_W - CNT_LSB - CNT_W;
    localparam logic [CNT_W-1:0] BLOCK_BYTES = CNT_W'(16);
    localparam logic [CNT_W-1:0] MIN_BYTES   = CNT_W'(1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HI       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LO       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HI        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LO        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_ENCRYPT = 3'd4;

    // Round sequencing.
    localparam int ROUND_W = 4;
    localparam logic [ROUND_W-1:0] FIRST_ROUND = 4'd1;
    localparam logic [ROUND_W-1:0] LAST_ROUND  = 4'd10;
    localparam logic [7:0]         RCON_FIRST  = 8'h01;
    localparam logic [7:0]         GF_POLY     = 8'h1b;

    // Forward S-box, entry 0 first.
    localparam logic [0:255][7:0] SBOX = {
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Multiplication by x in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
    endfunction

    // Next round key from the current one; words are most significant first.
    function automatic logic [BLK_W-1:0] key_next(input logic [BLK_W-1:0] rk,
                                                  input logic [7:0] rcon);
        logic [31:0] w3;
        logic [31:0] rot;
        logic [31:0] t;
        logic [31:0] n0;
        logic [31:0] n1;
        logic [31:0] n2;
        logic [31:0] n3;
        w3  = rk[31:0];
        rot = {w3[23:0], w3[31:24]};
        t   = {SBOX[rot[31:24]] ^ rcon, SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
        n0  = rk[127:96] ^ t;
        n1  = rk[95:64] ^ n0;
        n2  = rk[63:32] ^ n1;
        n3  = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // One cipher round: SubBytes, ShiftRows, MixColumns (not in the final round), AddRoundKey.
    // Byte i of the state sits at bits [127-8i -: 8].
    function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] s,
                                                   input logic [BLK_W-1:0] rk,
                                                   input logic final_rnd);
        logic [7:0]       sb [16];
        logic [7:0]       sr [16];
        logic [7:0]       a0;
        logic [7:0]       a1;
        logic [7:0]       a2;
        logic [7:0]       a3;
        logic [BLK_W-1:0] res;
        for (int i = 0; i < 16; i++) begin
            sb[i] = SBOX[s[127-8*i -: 8]];
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                sr[r+4*c] = sb[r+4*((c+r)&3)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = sr[4*c];
            a1 = sr[4*c+1];
            a2 = sr[4*c+2];
            a3 = sr[4*c+3];
            if (final_rnd) begin
                res[127-32*c -: 32] = {a0, a1, a2, a3};
            end else begin
                res[127-32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                                       a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                                       a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                                       xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
            end
        end
        return res ^ rk;
    endfunction

    // Keeps the leading cnt bytes and clears the rest.
    function automatic logic [BLK_W-1:0] byte_mask(input logic [CNT_W-1:0] cnt);
        logic [BLK_W-1:0] m;
        for (int i = 0; i < 16; i++) begin
            m[127-8*i -: 8] = (CNT_W'(i) < cnt) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

>>> rtl/core/aes128_cfb128_cipher.sv
// AES-128 CFB128 cipher top level with an iterative round unit.
//
// Usage:
// Keys, IV and direction go in over the always-ready configuration channel (i_cfg_valid,
// i_cfg_index, i_cfg_data); the user writes them only while the block is idle, which the
// block does not enforce. Reg 0/1 hold the key, 2/3 the IV, 4 bit 0 is encrypt (1) or decrypt (0).
// Blocks arrive on the s_axis channel: tdata holds data_hi, data_lo and byte_count from
// bit 0 up, tlast marks the final block of a message. Each block gives one result
// transfer on m_axis with the same layout, unused bytes cleared, tlast set at message end.
// On the first block of a message the key and IV are captured; round keys are then
// generated on the fly beside the rounds.
// Sequence: the accept cycle performs the initial key addition, one shared round unit then
// runs the ten rounds, and the finish state loads the result and the next feedback once the
// output register is free; only then is the next block taken, so blocks never overlap.
// The result sits in an output register; if the receiver stalls, the next block still
// runs its rounds and then waits until the output register frees.
// Reset (i_rst_n, synchronous, active low) closes any open message, empties the output
// register and restores the configuration registers to zero keys and encrypt mode.
module aes128_cfb128_cipher
    import aes_cfb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [HALF_W-1:0]    i_cfg_data,
    // Input blocks.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // data_hi[63:0], data_lo[127:64], byte_count[132:128]
    input  logic                 s_axis_tlast,
    // Result blocks.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // out_hi[63:0], out_lo[127:64], out_count[132:128]
    output logic                 m_axis_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // Control registers.
    logic [1:0]         r_state,     n_state;
    logic [ROUND_W-1:0] r_round,     n_round;
    logic               r_open,      n_open;
    logic               r_out_valid, n_out_valid;

    // Datapath registers.
    logic [7:0]         r_rcon,      n_rcon;
    logic [BLK_W-1:0]   r_rk,        n_rk;
    logic [BLK_W-1:0]   r_blk,       n_blk;
    logic [BLK_W-1:0]   r_key,       n_key;
    logic [BLK_W-1:0]   r_fb,        n_fb;
    logic [BLK_W-1:0]   r_din,       n_din;
    logic [CNT_W-1:0]   r_cnt,       n_cnt;
    logic               r_last,      n_last;
    logic [BLK_W-1:0]   r_out_data,  n_out_data;
    logic [CNT_W-1:0]   r_out_cnt,   n_out_cnt;
    logic               r_out_last,  n_out_last;

    // Configuration registers.
    logic [BLK_W-1:0]   r_cfg_key;
    logic [BLK_W-1:0]   r_cfg_iv;
    logic               r_cfg_mode;

    logic               in_xfer;
    logic               out_free;
    logic [CNT_W-1:0]   in_cnt;
    logic [BLK_W-1:0]   key_use;
    logic [BLK_W-1:0]   fb_use;
    logic [BLK_W-1:0]   rk_step;
    logic [BLK_W-1:0]   res;
    logic               full_blk;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Saturate the incoming byte count into the range one to sixteen.
    always_comb begin
        in_cnt = s_axis_tdata[CNT_LSB +: CNT_W];
        if (in_cnt == '0) begin
            in_cnt = MIN_BYTES;
        end else if (in_cnt > BLOCK_BYTES) begin
            in_cnt = BLOCK_BYTES;
        end
    end

    // Key and feedback come from the configuration at message start, else from the held copy.
    assign key_use  = r_open ? r_key : r_cfg_key;
    assign fb_use   = r_open ? r_fb  : r_cfg_iv;
    assign rk_step  = key_next(r_rk, r_rcon);
    assign full_blk = (r_cnt == BLOCK_BYTES);
    assign res      = (r_din ^ r_blk) & byte_mask(r_cnt);

    // Sequencer and datapath next values.
    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_open      = r_open;
        n_out_valid = r_out_valid;
        n_rcon      = r_rcon;
        n_rk        = r_rk;
        n_blk       = r_blk;
        n_key       = r_key;
        n_fb        = r_fb;
        n_din       = r_din;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_out_data  = r_out_data;
        n_out_cnt   = r_out_cnt;
        n_out_last  = r_out_last;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_key   = key_use;
                    n_fb    = fb_use;
                    n_open  = 1'b1;
                    n_rk    = key_use;
                    n_blk   = fb_use ^ key_use;
                    n_rcon  = RCON_FIRST;
                    n_round = FIRST_ROUND;
                    n_din   = {s_axis_tdata[HALF_W-1:0], s_axis_tdata[2*HALF_W-1:HALF_W]};
                    n_cnt   = in_cnt;
                    n_last  = s_axis_tlast;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_rk    = rk_step;
                n_blk   = aes_round(r_blk, rk_step, r_round == LAST_ROUND);
                n_rcon  = xtime(r_rcon);
                n_round = r_round + 1'b1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // Hand the result over and advance the feedback chain.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = res;
                    n_out_cnt   = r_cnt;
                    n_out_last  = r_last || !full_blk;
                    if (full_blk) begin
                        n_fb = r_cfg_mode ? res : r_din;
                    end
                    if (r_last || !full_blk) begin
                        n_open = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= FIRST_ROUND;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_open      <= n_open;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        r_rcon     <= n_rcon;
        r_rk       <= n_rk;
        r_blk      <= n_blk;
        r_key      <= n_key;
        r_fb       <= n_fb;
        r_din      <= n_din;
        r_cnt      <= n_cnt;
        r_last     <= n_last;
        r_out_data <= n_out_data;
        r_out_cnt  <= n_out_cnt;
        r_out_last <= n_out_last;
    end

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_key  <= '0;
            r_cfg_iv   <= '0;
            r_cfg_mode <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_KEY_HI:       r_cfg_key[BLK_W-1:HALF_W] <= i_cfg_data;
                REG_KEY_LO:       r_cfg_key[HALF_W-1:0]     <= i_cfg_data;
                REG_IV_HI:        r_cfg_iv[BLK_W-1:HALF_W]  <= i_cfg_data;
                REG_IV_LO:        r_cfg_iv[HALF_W-1:0]      <= i_cfg_data;
                REG_MODE_ENCRYPT: r_cfg_mode                <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_cnt, r_out_data[HALF_W-1:0],
                            r_out_data[BLK_W-1:HALF_W]};
    assign m_axis_tlast  = r_out_last;

endmodule

>>> rtl/core/aes_cfb_chk.sv
// Port-level assertion checker for the AES-128 CFB128 cipher, with its bind.
module aes_cfb_chk
    import aes_cfb_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast
);

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Once a block is taken, the block is busy on the next cycle.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again straight after a transfer");

    // Result byte counts stay between one and sixteen.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[CNT_LSB +: CNT_W] != '0)
            && (m_axis_tdata[CNT_LSB +: CNT_W] <= BLOCK_BYTES))
        else $error("result byte count out of range");

    // A partial block always closes the message.
    a_partial_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[CNT_LSB +: CNT_W] != BLOCK_BYTES) |-> m_axis_tlast)
        else $error("partial block without last mark");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind aes128_cfb128_cipher aes_cfb_chk u_aes_cfb_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
